[rtl/csr_pkg.sv]
// Shared types and constants for the convergence stop rule core.
// Holds the register map, the microcode word layout and the control program.
// Depends on nothing; used by convergence_stop_rule_core.
package csr_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int FIT_W  = 64;
	localparam int CNT_W  = 16;
	localparam int OGEN_W = 16;
	localparam int OVAR_W = 31;

	localparam logic [1:0] REG_METHOD    = 2'd0;
	localparam logic [1:0] REG_MAX_GEN   = 2'd1;
	localparam logic [1:0] REG_SIM_LIMIT = 2'd2;
	localparam logic [1:0] REG_TOLERANCE = 2'd3;

	localparam logic [0:0]        RST_METHOD    = 1'b0;
	localparam logic [CNT_W-1:0]  RST_MAX_GEN   = 16'd200;
	localparam logic [CNT_W-1:0]  RST_SIM_LIMIT = 16'd5;
	localparam logic [DATA_W-1:0] RST_TOLERANCE = 32'd42950;
	localparam logic [FIT_W-1:0]  Q_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic METHOD_DOUBLEBOX  = 1'b0;
	localparam logic METHOD_SIMILARITY = 1'b1;

	localparam int MIN_GEN = 5;

	typedef logic [3:0] pc_t;

	localparam logic [3:0] OP_NOP   = 4'd0;
	localparam logic [3:0] OP_DIFF  = 4'd1;
	localparam logic [3:0] OP_COUNT = 4'd2;
	localparam logic [3:0] OP_DIV   = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_VAR   = 4'd5;
	localparam logic [3:0] OP_BEST  = 4'd6;
	localparam logic [3:0] OP_SIM   = 4'd7;
	localparam logic [3:0] OP_EMIT  = 4'd8;

	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_NOIN    = 3'd2;
	localparam logic [2:0] C_SIM     = 3'd3;
	localparam logic [2:0] C_DIVMORE = 3'd4;
	localparam logic [2:0] C_OUTFREE = 3'd5;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] cond;
		pc_t        target;
	} ucode_t;

	localparam pc_t ST_WAIT  = 4'd0;
	localparam pc_t ST_DIFF  = 4'd1;
	localparam pc_t ST_COUNT = 4'd2;
	localparam pc_t ST_DIV   = 4'd3;
	localparam pc_t ST_MUL   = 4'd4;
	localparam pc_t ST_VAR   = 4'd5;
	localparam pc_t ST_BEST  = 4'd6;
	localparam pc_t ST_SIM   = 4'd7;
	localparam pc_t ST_EMIT  = 4'd8;
	localparam pc_t ST_HOLD  = 4'd9;

	localparam int UCODE_LEN = 10;

	localparam ucode_t UCODE [0:UCODE_LEN-1] = '{
		'{op: OP_NOP,   cond: C_NOIN,    target: ST_WAIT},
		'{op: OP_DIFF,  cond: C_SIM,     target: ST_SIM},
		'{op: OP_COUNT, cond: C_NEVER,   target: ST_WAIT},
		'{op: OP_DIV,   cond: C_DIVMORE, target: ST_DIV},
		'{op: OP_MUL,   cond: C_NEVER,   target: ST_WAIT},
		'{op: OP_VAR,   cond: C_NEVER,   target: ST_WAIT},
		'{op: OP_BEST,  cond: C_ALWAYS,  target: ST_EMIT},
		'{op: OP_SIM,   cond: C_NEVER,   target: ST_WAIT},
		'{op: OP_EMIT,  cond: C_OUTFREE, target: ST_WAIT},
		'{op: OP_NOP,   cond: C_ALWAYS,  target: ST_EMIT}
	};

endpackage

[rtl/convergence_stop_rule_core.sv]
// Convergence stop rule core: doublebox variance and similarity run stopping rules.
// In doublebox mode a restoring divider, one quotient bit a cycle, forms the improvement
// ratio; the similarity rule skips the divider.
// A new item is taken only once the previous one has reached the output register.
// Reset clears all counters, sets both stored bests to the largest value and loads
// the register defaults; a new item is taken while the previous result still waits.
module convergence_stop_rule_core
	import csr_pkg::*;
#(
	parameter int GEN_WIDTH = 16,
	parameter int FRAC_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [FIT_W-1:0]    best_fitness,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                stop,
	output logic [OGEN_W-1:0]   generation_number,
	output logic [OVAR_W-1:0]   variance_level
);

	localparam int DEN_W = GEN_WIDTH + 1;
	localparam int REM_W = GEN_WIDTH + 2;
	localparam int IT_W  = $clog2(FRAC_BITS);
	localparam int CMP_W = (GEN_WIDTH > CNT_W) ? GEN_WIDTH : CNT_W;

	logic                   method_q;
	logic [CNT_W-1:0]       max_gen_q;
	logic [CNT_W-1:0]       sim_limit_q;
	logic [DATA_W-1:0]      tol_q;

	pc_t                    pc_q;
	ucode_t                 uw;
	logic                   jump;
	pc_t                    pc_next;

	logic [FIT_W-1:0]       fit_q;
	logic [GEN_WIDTH-1:0]   gen_q;
	logic [GEN_WIDTH-1:0]   imp_q;
	logic [FIT_W-1:0]       best_q;
	logic [FRAC_BITS-1:0]   slevel_q;
	logic [FIT_W-1:0]       simval_q;
	logic [CNT_W-1:0]       simcnt_q;
	logic [FIT_W-1:0]       diff_q;
	logic                   lt_q;
	logic [REM_W-1:0]       rem_q;
	logic [DEN_W-1:0]       den_q;
	logic [FRAC_BITS-1:0]   quo_q;
	logic [IT_W-1:0]        it_q;
	logic [2*FRAC_BITS-1:0] prod_q;
	logic [FRAC_BITS-1:0]   var_q;

	logic                   out_valid_q;
	logic                   stop_q;
	logic [OGEN_W-1:0]      gen_out_q;
	logic [OVAR_W-1:0]      var_out_q;

	logic                   accept;
	logic                   cfg_write;
	logic                   out_free;
	logic [FIT_W-1:0]       ref_val;
	logic                   fit_lt;
	logic                   counts;
	logic [GEN_WIDTH-1:0]   imp_next;
	logic [REM_W-1:0]       rem_shift;
	logic [REM_W-1:0]       den_ext;
	logic                   sub_ok;
	logic                   stop_now;
	logic [CMP_W-1:0]       gen_cmp;
	logic [DATA_W-1:0]      var_ext;

	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite;
	assign accept     = item_valid && (pc_q == ST_WAIT);
	assign item_stall = (pc_q != ST_WAIT);
	assign out_free   = !out_valid_q || !result_stall;

	always_comb begin
		case (paddr[3:2])
			REG_METHOD:    prdata = DATA_W'(method_q);
			REG_MAX_GEN:   prdata = DATA_W'(max_gen_q);
			REG_SIM_LIMIT: prdata = DATA_W'(sim_limit_q);
			REG_TOLERANCE: prdata = tol_q;
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q    <= RST_METHOD;
			max_gen_q   <= RST_MAX_GEN;
			sim_limit_q <= RST_SIM_LIMIT;
			tol_q       <= RST_TOLERANCE;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_METHOD:    method_q    <= pwdata[0];
				REG_MAX_GEN:   max_gen_q   <= pwdata[CNT_W-1:0];
				REG_SIM_LIMIT: sim_limit_q <= pwdata[CNT_W-1:0];
				REG_TOLERANCE: tol_q       <= pwdata;
				default:       ;
			endcase
		end
	end

	assign uw = UCODE[pc_q];

	always_comb begin
		case (uw.cond)
			C_NEVER:   jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NOIN:    jump = !accept;
			C_SIM:     jump = (method_q == METHOD_SIMILARITY);
			C_DIVMORE: jump = (it_q != IT_W'(FRAC_BITS - 1));
			C_OUTFREE: jump = out_free;
			default:   jump = 1'b0;
		endcase
		pc_next = jump ? uw.target : pc_q + pc_t'(1);
	end

	assign ref_val  = (method_q == METHOD_SIMILARITY) ? simval_q : best_q;
	assign fit_lt   = $signed(fit_q) < $signed(ref_val);
	assign counts   = (gen_q <= GEN_WIDTH'(1)) || (diff_q > FIT_W'(tol_q));
	assign imp_next = (counts && (imp_q != '1)) ? imp_q + GEN_WIDTH'(1) : imp_q;

	assign rem_shift = {rem_q[REM_W-2:0], 1'b0};
	assign den_ext   = REM_W'(den_q);
	assign sub_ok    = rem_shift >= den_ext;

	assign gen_cmp = CMP_W'(gen_q);
	always_comb begin
		if (method_q == METHOD_SIMILARITY) begin
			stop_now = simcnt_q >= sim_limit_q;
		end else begin
			stop_now = (var_q <= slevel_q) && (gen_q >= GEN_WIDTH'(MIN_GEN));
		end
		stop_now = stop_now || (gen_cmp >= CMP_W'(max_gen_q));
	end

	assign var_ext = DATA_W'(var_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ST_WAIT;
			gen_q       <= '0;
			imp_q       <= '0;
			best_q      <= Q_MAX;
			slevel_q    <= '0;
			simval_q    <= Q_MAX;
			simcnt_q    <= '0;
			it_q        <= '0;
			var_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (accept && (gen_q != '1)) begin
				gen_q <= gen_q + GEN_WIDTH'(1);
			end
			if ((uw.op == OP_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_COUNT: begin
					imp_q <= imp_next;
					it_q  <= '0;
				end
				OP_DIV: begin
					it_q <= it_q + IT_W'(1);
				end
				OP_VAR: begin
					var_q <= quo_q - prod_q[2*FRAC_BITS-1:FRAC_BITS];
				end
				OP_BEST: begin
					if (lt_q) begin
						best_q   <= fit_q;
						slevel_q <= var_q >> 1;
					end
				end
				OP_SIM: begin
					if (diff_q < FIT_W'(tol_q)) begin
						if (simcnt_q != '1) begin
							simcnt_q <= simcnt_q + CNT_W'(1);
						end
					end else begin
						simcnt_q <= '0;
					end
					simval_q <= fit_q;
					var_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fit_q <= best_fitness;
		end
		case (uw.op)
			OP_DIFF: begin
				lt_q   <= fit_lt;
				diff_q <= fit_lt ? ref_val - fit_q : fit_q - ref_val;
			end
			OP_COUNT: begin
				rem_q <= REM_W'(imp_next);
				den_q <= DEN_W'(gen_q) + DEN_W'(1);
				quo_q <= '0;
			end
			OP_DIV: begin
				rem_q <= sub_ok ? rem_shift - den_ext : rem_shift;
				quo_q <= {quo_q[FRAC_BITS-2:0], sub_ok};
			end
			OP_MUL: begin
				prod_q <= quo_q * quo_q;
			end
			OP_EMIT: begin
				if (out_free) begin
					stop_q    <= stop_now;
					gen_out_q <= gen_cmp[OGEN_W-1:0];
					var_out_q <= var_ext[OVAR_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign result_valid      = out_valid_q;
	assign stop              = stop_q;
	assign generation_number = gen_out_q;
	assign variance_level    = var_out_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == ST_DIFF))
		else $error("Accepted item did not start the program.");

	a_imp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		imp_q <= gen_q)
		else $error("Improvement count exceeds generation count.");

	a_var_bound: assert property (@(posedge clk) disable iff (!arst_n)
		var_q <= (FRAC_BITS'(1) << (FRAC_BITS - 2)))
		else $error("Variance above one quarter.");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_DIV) |-> (rem_q < den_ext))
		else $error("Divider remainder not below divisor.");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for convergence_stop_rule_core: drives fitness items and APB register writes.
// Every verdict is predicted by a local model of both stopping rules and checked by field.
// Depends on csr_pkg and the core RTL only.
module testbench;
	import csr_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int REPORT_LIMIT = 10;
	localparam int FRAC_BITS = 32;
	localparam logic [FIT_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;
	localparam logic [CNT_W-1:0] CNT_TOP = 16'hFFFF;

	typedef struct packed {
		logic              stop;
		logic [OGEN_W-1:0] gen;
		logic [OVAR_W-1:0] level;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [FIT_W-1:0]  best_fitness = '0;
	logic              result_valid;
	logic              result_stall = 1'b1;
	logic              stop;
	logic [OGEN_W-1:0] generation_number;
	logic [OVAR_W-1:0] variance_level;

	logic              cfg_method = RST_METHOD;
	logic [CNT_W-1:0]  cfg_max_gen = RST_MAX_GEN;
	logic [CNT_W-1:0]  cfg_sim_limit = RST_SIM_LIMIT;
	logic [DATA_W-1:0] cfg_tolerance = RST_TOLERANCE;

	logic [CNT_W-1:0]  gen_count = '0;
	logic [CNT_W-1:0]  improve_count = '0;
	logic [CNT_W-1:0]  similar_count = '0;
	logic [FIT_W-1:0]  best_seen = Q_MAX;
	logic [FIT_W-1:0]  similar_value = Q_MAX;
	logic [31:0]       stop_level = '0;

	verdict_t pending_verdicts[$];
	int sender_gap_pct = 0;
	int receiver_stall_pct = 0;
	int holdoff_cycles = 0;
	int mismatches = 0;
	int cycle_count = 0;

	convergence_stop_rule_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.best_fitness(best_fitness),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.stop(stop),
		.generation_number(generation_number),
		.variance_level(variance_level)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string what, input string want, input string got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t %s: expected %s, got %s", $time, what, want, got);
	endtask

	function automatic string show(verdict_t v);
		return $sformatf("stop %0d gen %0d level %h", v.stop, v.gen, v.level);
	endfunction

	function automatic logic [FIT_W:0] fit_distance(logic [FIT_W-1:0] a, logic [FIT_W-1:0] b);
		logic signed [FIT_W:0] d;
		d = $signed({a[FIT_W-1], a}) - $signed({b[FIT_W-1], b});
		return d[FIT_W] ? -d : d;
	endfunction

	// Restoring division giving num/den as a Q0.32 fraction; num is always below den.
	function automatic logic [FRAC_BITS-1:0] ratio_q32(logic [CNT_W:0] num, logic [CNT_W:0] den);
		logic [CNT_W+1:0]     rem;
		logic [FRAC_BITS-1:0] q;
		rem = {1'b0, num};
		q = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic verdict_t predict_verdict(logic [FIT_W-1:0] fit);
		verdict_t             v;
		logic [FRAC_BITS-1:0] p, spread;
		logic [63:0]          prod;
		logic [FIT_W:0]       fit_gap;
		logic                 halt;
		if (gen_count != CNT_TOP)
			gen_count++;
		spread = '0;
		if (cfg_method == METHOD_DOUBLEBOX) begin
			fit_gap = fit_distance(fit, best_seen);
			if ((gen_count <= 1 || fit_gap > {33'b0, cfg_tolerance}) && improve_count != CNT_TOP)
				improve_count++;
			p = ratio_q32({1'b0, improve_count}, {1'b0, gen_count} + 1'b1);
			prod = p * p;
			spread = p - prod[63:FRAC_BITS];
			if ($signed(fit) < $signed(best_seen)) begin
				best_seen = fit;
				stop_level = spread >> 1;
			end
			halt = (spread <= stop_level && gen_count >= MIN_GEN) || gen_count >= cfg_max_gen;
		end else begin
			fit_gap = fit_distance(fit, similar_value);
			if (fit_gap < {33'b0, cfg_tolerance}) begin
				if (similar_count != CNT_TOP)
					similar_count++;
			end else begin
				similar_count = '0;
			end
			similar_value = fit;
			halt = similar_count >= cfg_sim_limit || gen_count >= cfg_max_gen;
		end
		v.stop = halt;
		v.gen = gen_count;
		v.level = spread[OVAR_W-1:0];
		return v;
	endfunction

	// Mostly values around the stored best or the previous value, so that both rules
	// see runs, improvements and tolerance edges; the rest is full-range noise or extreme values.
	function automatic logic [FIT_W-1:0] pick_fitness();
		logic [FIT_W-1:0] centre, step, r;
		centre = (cfg_method == METHOD_DOUBLEBOX) ? best_seen : similar_value;
		step = {32'b0, cfg_tolerance};
		r = {$urandom, $urandom};
		case ($urandom_range(11))
		0: return centre + step;
		1: return centre - step - 64'd1;
		2: return centre + step - 64'd1;
		3: return centre;
		4, 5, 6: return centre + (r % (2 * step + 64'd1)) - step;
		7, 8: return centre - (r >> $urandom_range(1, 63));
		9, 10: return r;
		default: begin
			case ($urandom_range(3))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			default: return '1;
			endcase
		end
		endcase
	endfunction

	task automatic reg_access(input logic [1:0] idx, input logic write,
			input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_check(input logic [1:0] idx);
		logic [DATA_W-1:0] held, back;
		case (idx)
		REG_METHOD: held = {31'b0, cfg_method};
		REG_MAX_GEN: held = {16'b0, cfg_max_gen};
		REG_SIM_LIMIT: held = {16'b0, cfg_sim_limit};
		default: held = cfg_tolerance;
		endcase
		reg_access(idx, 1'b0, '0, back);
		if (back !== held)
			note_mismatch($sformatf("register %0d", idx), $sformatf("%h", held),
				$sformatf("%h", back));
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] unused;
		reg_access(idx, 1'b1, data, unused);
		case (idx)
		REG_METHOD: cfg_method = data[0];
		REG_MAX_GEN: cfg_max_gen = data[CNT_W-1:0];
		REG_SIM_LIMIT: cfg_sim_limit = data[CNT_W-1:0];
		default: cfg_tolerance = data;
		endcase
		reg_check(idx);
	endtask

	task automatic send_fitness(input logic [FIT_W-1:0] fit);
		@(negedge clk);
		while ($urandom_range(99) < sender_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		best_fitness <= fit;
		do @(posedge clk); while (item_stall);
		pending_verdicts.push_back(predict_verdict(fit));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (holdoff_cycles > 0) begin
			holdoff_cycles = holdoff_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin : verdict_check
		verdict_t want, got;
		got.stop = stop;
		got.gen = generation_number;
		got.level = variance_level;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_verdicts.size() == 0) begin
				note_mismatch("unexpected verdict", "none", show(got));
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want)
					note_mismatch("verdict", show(want), show(got));
			end
		end
	end

	task automatic test_doublebox_rules();
		for (int i = 0; i < 4; i++)
			reg_check(i[1:0]);
		send_fitness(Q_MAX);
		send_fitness(Q_MIN);
		send_fitness(Q_MIN + {32'b0, cfg_tolerance});
		send_fitness(Q_MIN + {32'b0, cfg_tolerance} + 64'd1);
		send_fitness('0);
		send_fitness('1);
		repeat (4) send_fitness(Q_MIN);
		wait_drain();
	endtask

	task automatic test_similarity_rules();
		reg_write(REG_METHOD, {31'h7FFF_FFFF, METHOD_SIMILARITY});
		reg_write(REG_SIM_LIMIT, 32'h5A5A_0002);
		reg_write(REG_TOLERANCE, 32'd100);
		send_fitness(64'd0);
		send_fitness(64'd99);
		send_fitness(64'd199);
		send_fitness(64'd250);
		send_fitness(64'd300);
		send_fitness(Q_MAX);
		send_fitness(Q_MIN);
		wait_drain();
		reg_write(REG_SIM_LIMIT, 32'h0);
		reg_write(REG_TOLERANCE, 32'h0);
		send_fitness(64'd5);
		send_fitness(64'd5);
		wait_drain();
		reg_write(REG_TOLERANCE, 32'hFFFF_FFFF);
		reg_write(REG_MAX_GEN, 32'hABCD_0000);
		send_fitness(Q_MAX);
		send_fitness(Q_MIN);
		send_fitness('0);
		wait_drain();
		reg_write(REG_METHOD, {31'h7FFF_FFFF, METHOD_DOUBLEBOX});
		send_fitness(Q_MIN);
		send_fitness(Q_MAX);
		wait_drain();
	endtask

	task automatic test_backpressure();
		sender_gap_pct = 0;
		receiver_stall_pct = 0;
		reg_write(REG_METHOD, {31'b0, METHOD_SIMILARITY});
		reg_write(REG_MAX_GEN, 32'hFFFF);
		holdoff_cycles = 300;
		repeat (8) send_fitness(pick_fitness());
		wait_drain();
		reg_write(REG_METHOD, {31'b0, METHOD_DOUBLEBOX});
		holdoff_cycles = 300;
		repeat (6) send_fitness(pick_fitness());
		wait_drain();
		repeat (4) send_fitness(pick_fitness());
		wait_drain();
	endtask

	task automatic randomize_config(input logic method);
		logic [DATA_W-1:0] noise, tolerance;
		logic [CNT_W-1:0]  gen_cap, run_cap;
		noise = $urandom;
		case ($urandom_range(7))
		0: gen_cap = '0;
		1: gen_cap = 16'd1;
		2: gen_cap = '1;
		3, 4: gen_cap = gen_count + CNT_W'($urandom_range(1, 60));
		default: gen_cap = CNT_W'($urandom);
		endcase
		case ($urandom_range(5))
		0: run_cap = '0;
		1: run_cap = '1;
		default: run_cap = CNT_W'($urandom_range(1, 8));
		endcase
		case ($urandom_range(5))
		0: tolerance = '0;
		1: tolerance = '1;
		2: tolerance = $urandom;
		default: tolerance = $urandom_range(1, 200000);
		endcase
		reg_write(REG_METHOD, {noise[DATA_W-1:1], method});
		reg_write(REG_MAX_GEN, {noise[DATA_W-1:CNT_W], gen_cap});
		reg_write(REG_SIM_LIMIT, {noise[CNT_W-1:0], run_cap});
		reg_write(REG_TOLERANCE, tolerance);
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct);
		sender_gap_pct = gap_pct;
		receiver_stall_pct = stall_pct;
		for (int chunk = 0; chunk < 4; chunk++) begin
			randomize_config(chunk[0] ? METHOD_SIMILARITY : METHOD_DOUBLEBOX);
			repeat (90) send_fitness(pick_fitness());
			wait_drain();
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_doublebox_rules();
		test_similarity_rules();
		test_backpressure();
		test_random_traffic(0, 0);
		test_random_traffic(70, 0);
		test_random_traffic(0, 70);
		test_random_traffic(21, 21);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
